// ----- design/lcd_serial_link_engine_core_assert.svh -----
// Assertion macros shared by the checker files of the LCD serial link engine.
`ifndef LCD_SERIAL_LINK_ENGINE_CORE_ASSERT_SVH
`define LCD_SERIAL_LINK_ENGINE_CORE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define LSLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsle assertion failed");

// Consequent in the cycle after the antecedent.
`define LSLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsle assertion failed");

`endif

// ----- design/lsle_pkg.sv -----
// Package of the LCD serial link engine: constants, codes and interface types.
`timescale 1ns / 1ps
package lsle_pkg;

  localparam int NUM_PORTS    = 2;
  localparam int SCREEN_BYTES = 32;
  localparam int ROW_CHARS    = 16;
  localparam int FRAME_BYTES  = 22;
  localparam int STORE_DEPTH  = NUM_PORTS * SCREEN_BYTES;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int POS_W        = $clog2(FRAME_BYTES);
  localparam int FLAGS_POS    = 4;
  localparam int LAST_CHAR_POS = FRAME_BYTES - 2;

  localparam logic [7:0] SYNC0_BYTE = 8'hAA;
  localparam logic [7:0] SYNC1_BYTE = 8'h55;
  localparam logic [7:0] FRM_ID     = 8'h1E;
  localparam logic [7:0] FRM_LEN    = 8'h12;
  localparam logic [7:0] PKT_ID     = 8'h16;
  localparam logic [7:0] PKT_LEN    = 8'h02;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [7:0] FRAME_HDR [4] = '{SYNC0_BYTE, SYNC1_BYTE, FRM_ID, FRM_LEN};

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EMIT  = 2'd1,
    ACT_RECV  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic CFG_ACTIVE    = 1'b0;
  localparam logic CFG_BACKLIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_CHAR,
    ST_SUM,
    ST_REPORT
  } state_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SYNC0,
    PS_SYNC1,
    PS_ID,
    PS_LEN
  } parse_t;

  typedef enum logic [2:0] {
    OSEL_HDR,
    OSEL_FLAGS,
    OSEL_CHAR,
    OSEL_SUM,
    OSEL_REPORT
  } out_sel_t;

  typedef struct packed {
    logic       take;
    logic       load_out;
    out_sel_t   sel;
    logic [1:0] hdr_idx;
    logic       rd_next;
  } lsle_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic port_ok;
    logic port_active;
  } lsle_stat_t;

endpackage

// ----- design/lsle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lsle_ctrl.sv -----
// Controller state machine: sequences requests and the bytes of a frame.
`timescale 1ns / 1ps
module lsle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  input  lsle_pkg::lsle_stat_t stat,
  output logic               in_stall,
  output lsle_pkg::lsle_cmd_t  cmd
);
  import lsle_pkg::*;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_EMIT && stat.port_ok && stat.port_active) begin
            state_nxt = ST_HDR;
            pos_nxt   = '0;
          end else if (in_action == ACT_RECV && stat.port_ok) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_HDR: begin
        if (stat.slot_free) begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r == POS_W'(FLAGS_POS)) begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        if (stat.slot_free) begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r == POS_W'(LAST_CHAR_POS)) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM, ST_REPORT: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.sel  = OSEL_HDR;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
      end
      ST_HDR: begin
        cmd.load_out = stat.slot_free;
        cmd.hdr_idx  = pos_r[1:0];
        // The first character is fetched while the flags byte goes out.
        if (pos_r == POS_W'(FLAGS_POS)) begin
          cmd.sel     = OSEL_FLAGS;
          cmd.rd_next = stat.slot_free;
        end
      end
      ST_CHAR: begin
        cmd.load_out = stat.slot_free;
        cmd.sel      = OSEL_CHAR;
        cmd.rd_next  = stat.slot_free && (pos_r != POS_W'(LAST_CHAR_POS));
      end
      ST_SUM: begin
        cmd.load_out = stat.slot_free;
        cmd.sel      = OSEL_SUM;
      end
      ST_REPORT: begin
        cmd.load_out = stat.slot_free;
        cmd.sel      = OSEL_REPORT;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- design/lsle_dpath.sv -----
// Datapath: screen store, per-port state, configuration and output register.
`timescale 1ns / 1ps
module lsle_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic [1:0]         in_action,
  input  logic               in_port,
  input  logic               in_line,
  input  logic [3:0]         in_column,
  input  logic [7:0]         in_char_value,
  input  logic               out_stall,
  input  lsle_pkg::lsle_cmd_t  cmd,
  output lsle_pkg::lsle_stat_t stat,
  output logic               out_valid,
  output logic               out_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last,
  output logic [7:0]         out_buttons
);
  import lsle_pkg::*;

  // Configuration and per-port state.
  logic [1:0]           active_r, backlight_r;
  logic                 row_r   [NUM_PORTS];
  logic                 row_nxt [NUM_PORTS];
  parse_t               stage_r   [NUM_PORTS];
  parse_t               stage_nxt [NUM_PORTS];
  logic [7:0]           btn_r   [NUM_PORTS];
  logic [7:0]           btn_nxt [NUM_PORTS];
  logic [NUM_PORTS-1:0] act_old, act_new;

  // Item and frame registers.
  logic                 port_r, item_act_r, row_sel_r;
  logic [7:0]           byte_r, flags_r, sum_r;
  logic                 ended_r;
  logic [3:0]           char_idx_r;

  // Screen store and its valid bits.
  logic [STORE_DEPTH-1:0] vld_r;
  logic                   rd_vld_r;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [7:0]             rd_data;

  // Output register.
  logic       out_valid_r;
  logic       out_kind_r, out_last_r;
  logic [7:0] out_tx_r, out_btn_r;
  logic       out_kind_nxt, out_last_nxt;
  logic [7:0] out_tx_nxt, out_btn_nxt;

  logic       emit_go;
  logic [7:0] flags_new;
  logic [7:0] raw_char, char_out;
  logic       ended_now;
  parse_t     ps_nxt;
  logic [7:0] ps_btn;

  assign stat.slot_free   = !out_valid_r || !out_stall;
  assign stat.port_ok     = int'(in_port) < NUM_PORTS;
  assign stat.port_active = active_r[in_port];

  assign wr_en   = cmd.take && (in_action == ACT_WRITE) && stat.port_ok;
  assign wr_addr = ADDR_W'({in_port, in_line, in_column});
  assign rd_addr = ADDR_W'({port_r, row_sel_r, char_idx_r});
  assign emit_go = cmd.take && (in_action == ACT_EMIT) && stat.port_ok &&
                   stat.port_active;
  assign flags_new = {6'b0, backlight_r[in_port], row_r[in_port]};

  lsle_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_char_value),
    .re    (cmd.rd_next),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // A location never written reads as zero, which also ends the line.
  always_comb begin
    raw_char  = rd_vld_r ? rd_data : 8'h00;
    ended_now = ended_r || (raw_char == 8'h00);
    char_out  = ended_now ? SPACE_CHAR : raw_char;
  end

  // Button packet parser for the port of the held request.
  always_comb begin
    ps_btn = btn_r[port_r];
    if (byte_r == SYNC0_BYTE) begin
      ps_nxt = PS_SYNC0;
    end else if (byte_r == SYNC1_BYTE && stage_r[port_r] == PS_SYNC0) begin
      ps_nxt = PS_SYNC1;
    end else if (byte_r == PKT_ID && stage_r[port_r] == PS_SYNC1) begin
      ps_nxt = PS_ID;
    end else if (byte_r == PKT_LEN && stage_r[port_r] == PS_ID) begin
      ps_nxt = PS_LEN;
    end else if (stage_r[port_r] == PS_LEN) begin
      ps_btn = byte_r;
      ps_nxt = PS_IDLE;
    end else begin
      ps_nxt = PS_IDLE;
    end
  end

  always_comb begin
    act_old = NUM_PORTS'(active_r);
    act_new = NUM_PORTS'(cfg_wdata);
    row_nxt   = row_r;
    stage_nxt = stage_r;
    btn_nxt   = btn_r;
    if (emit_go) begin
      row_nxt[in_port] = ~row_r[in_port];
    end
    if (cmd.load_out && cmd.sel == OSEL_REPORT && item_act_r) begin
      stage_nxt[port_r] = ps_nxt;
      btn_nxt[port_r]   = ps_btn;
    end
    // Turning a port on starts its protocol state afresh.
    if (cfg_we && cfg_index == CFG_ACTIVE) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (act_new[p] && !act_old[p]) begin
          row_nxt[p]   = 1'b0;
          stage_nxt[p] = PS_IDLE;
          btn_nxt[p]   = 8'h00;
        end
      end
    end
  end

  always_comb begin
    out_kind_nxt = KIND_TX;
    out_last_nxt = 1'b0;
    out_btn_nxt  = 8'h00;
    case (cmd.sel)
      OSEL_HDR:   out_tx_nxt = FRAME_HDR[cmd.hdr_idx];
      OSEL_FLAGS: out_tx_nxt = flags_r;
      OSEL_CHAR:  out_tx_nxt = char_out;
      OSEL_SUM: begin
        out_tx_nxt   = 8'h00 - sum_r;
        out_last_nxt = 1'b1;
      end
      OSEL_REPORT: begin
        out_kind_nxt = KIND_REPORT;
        out_tx_nxt   = 8'h00;
        out_last_nxt = 1'b1;
        out_btn_nxt  = item_act_r ? ps_btn : 8'h00;
      end
      default: out_tx_nxt = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      backlight_r <= '0;
      row_r       <= '{default: 1'b0};
      stage_r     <= '{default: PS_IDLE};
      btn_r       <= '{default: 8'h00};
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      stage_r <= stage_nxt;
      btn_r   <= btn_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_ACTIVE) begin
          active_r <= cfg_wdata;
        end else begin
          backlight_r <= cfg_wdata;
        end
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      port_r     <= in_port;
      byte_r     <= in_char_value;
      item_act_r <= stat.port_active;
      row_sel_r  <= row_r[in_port];
      flags_r    <= flags_new;
      sum_r      <= flags_new;
      ended_r    <= 1'b0;
      char_idx_r <= '0;
    end
    if (cmd.rd_next) begin
      rd_vld_r   <= vld_r[rd_addr];
      char_idx_r <= char_idx_r + 4'd1;
    end
    if (cmd.load_out && cmd.sel == OSEL_CHAR) begin
      sum_r   <= sum_r + char_out;
      ended_r <= ended_now;
    end
    if (cmd.load_out) begin
      out_kind_r <= out_kind_nxt;
      out_tx_r   <= out_tx_nxt;
      out_last_r <= out_last_nxt;
      out_btn_r  <= out_btn_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_tx_byte = out_tx_r;
  assign out_last    = out_last_r;
  assign out_buttons = out_btn_r;

endmodule

// ----- design/lcd_serial_link_engine_core.sv -----
// Top level of the LCD serial link engine: controller plus datapath.
`timescale 1ns / 1ps
// A received byte yields one button report. An emit on an active port sends
// 22 frame bytes, one per cycle while the result side does not stall, set by
// the single output register and the one read of the screen store per
// character, which is fetched while the byte before it goes out. Stalls on
// the result side hold the frame, and no new request is taken until it ends.
// The screen store reads as zero until written, through per-entry valid bits,
// so there is no clearing pass.
module lcd_serial_link_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic       in_port,
  input  logic       in_line,
  input  logic [3:0] in_column,
  input  logic [7:0] in_char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic [7:0] out_buttons
);
  import lsle_pkg::*;

  lsle_cmd_t  cmd;
  lsle_stat_t stat;

  lsle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  lsle_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_port       (in_port),
    .in_line       (in_line),
    .in_column     (in_column),
    .in_char_value (in_char_value),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_last),
    .out_buttons   (out_buttons)
  );

endmodule

// ----- design/lsle_checker.sv -----
// Port-level assertion checker for the LCD serial link engine and its bind.
`timescale 1ns / 1ps
`include "lcd_serial_link_engine_core_assert.svh"
module lsle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_tx_byte,
  input logic       out_last,
  input logic [7:0] out_buttons
);
  import lsle_pkg::*;

  logic        shape_ok;
  logic [17:0] out_payload;

  // Reports carry no frame byte and end their request; frame bytes carry no buttons.
  assign shape_ok = (out_kind == KIND_REPORT) ? (out_tx_byte == 8'h00 && out_last)
                                              : (out_buttons == 8'h00);
  assign out_payload = {out_kind, out_tx_byte, out_last, out_buttons};

  // A received byte always owes a report, so the input side must close.
  `LSLE_ASSERT_NEXT(a_recv_blocks, in_valid && !in_stall && in_action == ACT_RECV, in_stall)

  // A character write produces nothing and leaves the block ready.
  `LSLE_ASSERT_NEXT(a_write_ready, in_valid && !in_stall && in_action == ACT_WRITE, !in_stall)

  `LSLE_ASSERT_NOW(a_result_shape, out_valid, shape_ok)

  `LSLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

endmodule

bind lcd_serial_link_engine_core lsle_checker u_lsle_checker (.*);
